@@ sv/sab_pkg.sv @@
// Shared constants and payload types of the suffix and LCP array builder.
`default_nettype none
package sab_pkg;
    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = IDX_W + 1;
    localparam int RANK_W  = 8;
    localparam int KEY_W   = 2 * RANK_W + 1;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [5:0] suffix_start;
        logic [5:0] common_prefix;
        logic       last_result;
    } out_item_t;
endpackage
`default_nettype wire

@@ sv/suffix_and_lcp_array_builder.sv @@
// Suffix array and LCP array builder over a string of up to MAX_LEN bytes.
`default_nettype none
// The block takes one byte per transfer while loading; bytes past MAX_LEN are
// dropped, and the byte flagged end_of_text starts the build. The build runs
// ceil(log2 n) doubling rounds; each round ranks every position by counting the
// positions whose (rank, rank k on) pair is smaller, streaming the rank memory
// through its two read ports at one position a cycle. Kasai's pass then compares
// the bytes of each suffix and its predecessor in the suffix array until they
// differ, and each of the n results waits for out_ready before the next.
// No input is taken from end_of_text until the last result is transferred.
module suffix_and_lcp_array_builder
    import sab_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);
    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;
    localparam logic [3:0] ST_KI   = 4'd2;
    localparam logic [3:0] ST_KI2  = 4'd3;
    localparam logic [3:0] ST_CNT  = 4'd4;
    localparam logic [3:0] ST_COPY = 4'd5;
    localparam logic [3:0] ST_SA   = 4'd6;
    localparam logic [3:0] ST_KA   = 4'd7;
    localparam logic [3:0] ST_KB   = 4'd8;
    localparam logic [3:0] ST_KC   = 4'd9;
    localparam logic [3:0] ST_KD   = 4'd10;
    localparam logic [3:0] ST_KE   = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;
    localparam logic [3:0] ST_OUT2 = 4'd13;
    localparam logic [3:0] ST_OUTW = 4'd14;

    logic [7:0]        text_mem [MAX_LEN];
    logic [RANK_W-1:0] rank_mem [MAX_LEN];
    logic [RANK_W-1:0] next_mem [MAX_LEN];
    logic [IDX_W-1:0]  sa_mem   [MAX_LEN];
    logic [IDX_W-1:0]  lcp_mem  [MAX_LEN];

    logic [3:0]        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [LEN_W-1:0]  i_reg, i_next;
    logic [LEN_W-1:0]  c_reg, c_next;
    logic [LEN_W-1:0]  h_reg, h_next;
    logic [IDX_W-1:0]  pa_reg, pa_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  jpos_reg, jpos_next;
    logic [RANK_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0]  keyi_reg, keyi_next;
    logic              pv_reg, pv_next;
    logic              ok_reg, ok_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [IDX_W-1:0]  text_ra, text_rb, rank_ra, rank_rb, next_ra, sa_ra, lcp_ra;
    logic [7:0]        text_qa, text_qb;
    logic [RANK_W-1:0] rank_qa, rank_qb, next_q;
    logic [IDX_W-1:0]  sa_q, lcp_q;

    logic              text_we, rank_we, next_we, sa_we, lcp_we;
    logic [IDX_W-1:0]  text_wa, rank_wa, next_wa, sa_wa, lcp_wa;
    logic [7:0]        text_wd;
    logic [RANK_W-1:0] rank_wd, next_wd;
    logic [IDX_W-1:0]  sa_wd, lcp_wd;

    logic [LEN_W-1:0]  sum_a, sum_b;
    logic [KEY_W-1:0]  keyj;
    logic              kasai_done;
    logic              in_fire, out_fire;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    // Pair key of the streamed position; zero second half means past the end.
    assign keyj = {rank_qa, ok_reg ? ({1'b0, rank_qb} + 9'd1) : 9'd0};

    always_ff @(posedge clk)
    begin
        text_qa <= text_mem[text_ra];
        text_qb <= text_mem[text_rb];
        rank_qa <= rank_mem[rank_ra];
        rank_qb <= rank_mem[rank_rb];
        next_q  <= next_mem[next_ra];
        sa_q    <= sa_mem[sa_ra];
        lcp_q   <= lcp_mem[lcp_ra];
        if (text_we)
        begin
            text_mem[text_wa] <= text_wd;
        end
        if (rank_we)
        begin
            rank_mem[rank_wa] <= rank_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (sa_we)
        begin
            sa_mem[sa_wa] <= sa_wd;
        end
        if (lcp_we)
        begin
            lcp_mem[lcp_wa] <= lcp_wd;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        c_next         = c_reg;
        h_next         = h_reg;
        pa_next        = pa_reg;
        r_next         = r_reg;
        jpos_next      = jpos_reg;
        cnt_next       = cnt_reg;
        keyi_next      = keyi_reg;
        pv_next        = 1'b0;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        text_ra = c_reg[IDX_W-1:0];
        text_rb = c_reg[IDX_W-1:0];
        rank_ra = c_reg[IDX_W-1:0];
        rank_rb = c_reg[IDX_W-1:0];
        next_ra = c_reg[IDX_W-1:0];
        sa_ra   = r_reg;
        lcp_ra  = r_reg;

        text_we = 1'b0; text_wa = len_reg[IDX_W-1:0]; text_wd = in_data.symbol;
        rank_we = 1'b0; rank_wa = pa_reg;             rank_wd = next_q;
        next_we = 1'b0; next_wa = i_reg[IDX_W-1:0];   next_wd = cnt_reg;
        sa_we   = 1'b0; sa_wa   = rank_qa[IDX_W-1:0]; sa_wd   = pa_reg;
        lcp_we  = 1'b0; lcp_wa  = r_reg;              lcp_wd  = h_reg[IDX_W-1:0];

        sum_a      = i_reg + h_reg;
        sum_b      = {1'b0, jpos_reg} + h_reg;
        kasai_done = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (len_reg < LEN_W'(MAX_LEN))
                    begin
                        text_we  = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                    if (in_data.end_of_text)
                    begin
                        c_next     = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT, ST_COPY, ST_SA:
            begin
                // Stream c through a read, write back in the next cycle at pa (SA: at its rank).
                if (c_reg < len_reg)
                begin
                    pv_next = 1'b1;
                    pa_next = c_reg[IDX_W-1:0];
                    c_next  = c_reg + LEN_W'(1);
                end
                if (pv_reg)
                begin
                    if (state_reg == ST_INIT)
                    begin
                        // A lone byte skips the rounds and already has rank 0.
                        rank_we = 1'b1;
                        rank_wd = (len_reg == LEN_W'(1)) ? '0 : text_qa;
                    end
                    else if (state_reg == ST_COPY)
                    begin
                        rank_we = 1'b1;
                    end
                    else
                    begin
                        sa_we = 1'b1;
                    end
                end
                else if (c_reg == len_reg)
                begin
                    c_next = '0;
                    i_next = '0;
                    h_next = '0;
                    if (state_reg == ST_SA)
                    begin
                        state_next = ST_KA;
                    end
                    else
                    begin
                        if (state_reg == ST_INIT)
                        begin
                            k_next = LEN_W'(1);
                        end
                        else
                        begin
                            k_next = k_reg << 1;
                        end
                        if ({1'b0, k_next} < {1'b0, len_reg})
                        begin
                            state_next = ST_KI;
                        end
                        else
                        begin
                            state_next = ST_SA;
                        end
                    end
                end
            end
            ST_KI:
            begin
                rank_ra    = i_reg[IDX_W-1:0];
                rank_rb    = IDX_W'(i_reg + k_reg);
                ok_next    = ({1'b0, i_reg} + {1'b0, k_reg}) < {1'b0, len_reg};
                state_next = ST_KI2;
            end
            ST_KI2:
            begin
                keyi_next  = keyj;
                c_next     = '0;
                cnt_next   = '0;
                state_next = ST_CNT;
            end
            ST_CNT:
            begin
                rank_ra = c_reg[IDX_W-1:0];
                rank_rb = IDX_W'(c_reg + k_reg);
                if (c_reg < len_reg)
                begin
                    pv_next = 1'b1;
                    ok_next = ({1'b0, c_reg} + {1'b0, k_reg}) < {1'b0, len_reg};
                    c_next  = c_reg + LEN_W'(1);
                end
                if (pv_reg)
                begin
                    if (keyj < keyi_reg)
                    begin
                        cnt_next = cnt_reg + RANK_W'(1);
                    end
                end
                else if (c_reg == len_reg)
                begin
                    next_we = 1'b1;
                    i_next  = i_reg + LEN_W'(1);
                    c_next  = '0;
                    if (i_next == len_reg)
                    begin
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_KI;
                    end
                end
            end
            ST_KA:
            begin
                rank_ra    = i_reg[IDX_W-1:0];
                state_next = ST_KB;
            end
            ST_KB:
            begin
                r_next = rank_qa[IDX_W-1:0];
                sa_ra  = IDX_W'(rank_qa - RANK_W'(1));
                if (rank_qa == '0)
                begin
                    i_next = i_reg + LEN_W'(1);
                    if (i_next == len_reg)
                    begin
                        r_next     = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_KA;
                    end
                end
                else
                begin
                    state_next = ST_KC;
                end
            end
            ST_KC:
            begin
                jpos_next  = sa_q;
                state_next = ST_KD;
            end
            ST_KD:
            begin
                text_ra = sum_a[IDX_W-1:0];
                text_rb = sum_b[IDX_W-1:0];
                if (sum_a < len_reg && sum_b < len_reg)
                begin
                    state_next = ST_KE;
                end
                else
                begin
                    kasai_done = 1'b1;
                end
            end
            ST_KE:
            begin
                if (text_qa == text_qb)
                begin
                    h_next     = h_reg + LEN_W'(1);
                    state_next = ST_KD;
                end
                else
                begin
                    kasai_done = 1'b1;
                end
            end
            ST_OUT:
            begin
                state_next = ST_OUT2;
            end
            ST_OUT2:
            begin
                out_data_next.suffix_start  = sa_q;
                out_data_next.common_prefix = (r_reg == '0) ? '0 : lcp_q;
                out_data_next.last_result   = ({1'b0, r_reg} + LEN_W'(1)) == len_reg;
                out_valid_next              = 1'b1;
                state_next                  = ST_OUTW;
            end
            ST_OUTW:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (out_data_reg.last_result)
                    begin
                        len_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        r_next     = r_reg + IDX_W'(1);
                        state_next = ST_OUT;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (kasai_done)
        begin
            // Record the match length, drop it by one for the next position.
            lcp_we = 1'b1;
            if (h_reg != '0)
            begin
                h_next = h_reg - LEN_W'(1);
            end
            i_next = i_reg + LEN_W'(1);
            if (i_next == len_reg)
            begin
                r_next     = '0;
                state_next = ST_OUT;
            end
            else
            begin
                state_next = ST_KA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            len_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        i_reg        <= i_next;
        c_reg        <= c_next;
        h_reg        <= h_next;
        pa_reg       <= pa_next;
        r_reg        <= r_next;
        jpos_reg     <= jpos_next;
        cnt_reg      <= cnt_next;
        keyi_reg     <= keyi_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LEN))
        else $error("byte count past store depth");

    a_eot_starts_build: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.end_of_text |=> state_reg == ST_INIT)
        else $error("end of text did not start the build");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_data_reg.last_result |=> state_reg == ST_LOAD && len_reg == '0)
        else $error("final transfer did not return to loading");

    a_valid_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_OUTW)
        else $error("result shown outside the output wait");

    a_nonempty_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD && $past(state_reg) == ST_INIT |-> 1'b0)
        else $error("build aborted");
endmodule
`default_nettype wire
